// File: rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and table functions of the space vector PWM unit.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

   // Fixed field widths
   localparam int unsigned ANGLE_BITS  = 13;
   localparam int unsigned MAG_BITS    = 16;
   localparam int unsigned PERIOD_BITS = 16;
   localparam int unsigned SECTOR_BITS = 3;
   localparam int unsigned NUM_SECTORS = 6;

   // Q1.15 unity magnitude, binary point of the magnitude
   localparam logic [MAG_BITS-1:0] MAG_ONE  = 16'd32768;
   localparam int unsigned         MAG_FRAC = 15;

   // Reset value of the period register
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd4096;

   // pi/3 in Q30
   localparam logic [63:0] PI3_Q30 = 64'd1124419809;

   // Fraction of the period that a phase is held for
   typedef enum logic [1:0] {
      SEL_HALF = 2'd0,   // t0/2
      SEL_T1   = 2'd1,   // t0/2 + t1
      SEL_T2   = 2'd2,   // t0/2 + t2
      SEL_ALL  = 2'd3    // t0/2 + t1 + t2
   } sel_type;

   typedef struct packed {
      sel_type u;
      sel_type v;
      sel_type w;
   } sel_row_type;

   // Load enables of the two stages inside each phase compare slice
   typedef struct packed {
      logic load_mul;
      logic load_out;
   } stage_ctl_type;

   // Per-sector phase pattern, phases U, V, W
   function automatic sel_row_type phase_row(input logic [SECTOR_BITS-1:0] sector);
      sel_row_type row;
      unique case (sector)
         3'd0:    row = '{u: SEL_HALF, v: SEL_T1,   w: SEL_ALL};
         3'd1:    row = '{u: SEL_T2,   v: SEL_HALF, w: SEL_ALL};
         3'd2:    row = '{u: SEL_ALL,  v: SEL_HALF, w: SEL_T1};
         3'd3:    row = '{u: SEL_ALL,  v: SEL_T2,   w: SEL_HALF};
         3'd4:    row = '{u: SEL_T1,   v: SEL_ALL,  w: SEL_HALF};
         3'd5:    row = '{u: SEL_HALF, v: SEL_ALL,  w: SEL_T2};
         default: row = '{u: SEL_HALF, v: SEL_HALF, w: SEL_HALF};
      endcase
      return row;
   endfunction

   // Sine table entry k: 9-term Taylor series in Q30, rounded to sine_bits.
   // Evaluated at elaboration only.
   function automatic logic [31:0] sine_entry(input int unsigned k,
                                              input int unsigned frac_bits,
                                              input int unsigned sine_bits);
      logic [63:0] x;
      logic [63:0] acc;
      logic [63:0] term;
      x    = (64'(k) * PI3_Q30) >> frac_bits;
      acc  = x;
      term = x;
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         unique case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            7:       term = term / 64'd210;
            default: term = term / 64'd272;
         endcase
         if (n[0]) begin
            acc = (acc >= term) ? acc - term : 64'd0;
         end else begin
            acc = acc + term;
         end
      end
      return 32'((acc + (64'd1 << (29 - sine_bits))) >> (30 - sine_bits));
   endfunction

endpackage

`default_nettype wire

// File: rtl/svpwm_sine_rom.sv
// ----------------------------------------------------------------------------
// svpwm_sine_rom
// Sine table over 0 to 60 degrees with two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_sine_rom #(
   parameter int unsigned FRAC_BITS = 10,
   parameter int unsigned DATA_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [FRAC_BITS:0]   rd_addr_a,
   input  wire logic [FRAC_BITS:0]   rd_addr_b,
   output logic      [DATA_BITS-1:0] rd_data_a,
   output logic      [DATA_BITS-1:0] rd_data_b
);

   localparam int unsigned DEPTH = (2 ** FRAC_BITS) + 1;

   typedef logic [DATA_BITS-1:0] rom_type [DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < DEPTH; k++) begin
         r[k] = DATA_BITS'(svpwm_pkg::sine_entry(int'(k), FRAC_BITS, DATA_BITS));
      end
      return r;
   endfunction

   localparam rom_type SINE_TABLE = build_rom();

   logic [DATA_BITS-1:0] data_a_ff;
   logic [DATA_BITS-1:0] data_b_ff;

   // Read both ports, hold while the stage is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= SINE_TABLE[rd_addr_a];
         data_b_ff <= SINE_TABLE[rd_addr_b];
      end
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

`default_nettype wire

// File: rtl/svpwm_phase_cmp.sv
// ----------------------------------------------------------------------------
// svpwm_phase_cmp
// One phase: scale the on-time fraction by the period, then form the compare.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_phase_cmp #(
   parameter int unsigned SINE_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire svpwm_pkg::stage_ctl_type               ctl,
   input  wire logic [SINE_BITS:0]                     frac,
   input  wire logic [svpwm_pkg::PERIOD_BITS-1:0]      period,
   output logic      [svpwm_pkg::PERIOD_BITS-1:0]      compare
);

   localparam int unsigned PB     = svpwm_pkg::PERIOD_BITS;
   localparam int unsigned PROD_W = SINE_BITS + 1 + PB;
   localparam int unsigned SUM_W  = PROD_W + 1;
   localparam int unsigned SUB_W  = SUM_W - SINE_BITS;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PB-1:0]     compare_ff;
   logic [PB-1:0]     compare_in;
   logic [SUM_W-1:0]  round_sum;
   logic [SUB_W-1:0]  sub;

   // Multiply the fraction by the period
   assign prod_in = PROD_W'(frac) * PROD_W'(period);

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         prod_ff <= prod_in;
      end
   end

   // Round the product up to timer counts, subtract from the period
   always_comb begin
      round_sum  = SUM_W'(prod_ff) + ((SUM_W'(1) << SINE_BITS) - SUM_W'(1));
      sub        = SUB_W'(round_sum >> SINE_BITS);
      compare_in = (SUB_W'(period) > sub) ? PB'(SUB_W'(period) - sub) : '0;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         compare_ff <= compare_in;
      end
   end

   assign compare = compare_ff;

endmodule

`default_nettype wire

// File: rtl/space_vector_pwm_unit.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_unit
// Three-phase space vector PWM: angle and magnitude in, timer compares out.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock cycle while the output is not stalled;
// each accepted beat passes in order through sine table read, vector
// time multiply, null time and phase fraction select, period multiply, and
// compare rounding, one register stage each. Stages fill bubbles, so a new
// beat is taken while a finished result waits as long as any stage is empty.
// Angles in sectors 6 and 7 are dropped at the input and give no result.
// The sine table holds 2^SECTOR_FRAC_BITS+1 entries and is read at two
// addresses in the first stage. The pwm_period register may be written only
// while no beat is in flight; csr_ready is always high.
`default_nettype none

module space_vector_pwm_unit #(
   parameter int unsigned SECTOR_FRAC_BITS = 10,
   parameter int unsigned SINE_BITS        = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration write
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [svpwm_pkg::PERIOD_BITS-1:0]     csr_pwm_period,
   // input channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [svpwm_pkg::ANGLE_BITS-1:0]      req_angle,
   input  wire logic [svpwm_pkg::MAG_BITS-1:0]        req_magnitude,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [svpwm_pkg::PERIOD_BITS-1:0]     rsp_compare_u,
   output logic      [svpwm_pkg::PERIOD_BITS-1:0]     rsp_compare_v,
   output logic      [svpwm_pkg::PERIOD_BITS-1:0]     rsp_compare_w,
   output logic      [svpwm_pkg::SECTOR_BITS-1:0]     rsp_sector_out
);

   localparam int unsigned AB      = svpwm_pkg::ANGLE_BITS;
   localparam int unsigned MB      = svpwm_pkg::MAG_BITS;
   localparam int unsigned PB      = svpwm_pkg::PERIOD_BITS;
   localparam int unsigned SB      = svpwm_pkg::SECTOR_BITS;
   localparam int unsigned FB      = SECTOR_FRAC_BITS;
   localparam int unsigned EXT_W   = AB + FB;
   localparam int unsigned MPROD_W = MB + SINE_BITS;
   localparam int unsigned STAGES  = 5;

   // ---------------------------------------------------------------- config
   logic [PB-1:0] period_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= svpwm_pkg::PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         period_ff <= csr_pwm_period;
      end
   end

   // -------------------------------------------------------- stage control
   logic [STAGES:1]   valid_ff;
   logic [STAGES:1]   valid_in;
   logic [STAGES+1:1] load;
   logic              sector_ok;

   // Load a stage when it is empty or its contents move on
   always_comb begin
      load[STAGES+1] = !rsp_stall;
      for (int k = STAGES; k >= 1; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign req_stall = !load[1];

   always_comb begin
      valid_in[1] = req_valid && sector_ok;
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (load[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // ----------------------------------------------- stage 1: decode, table
   logic [EXT_W-1:0] angle_ext;
   logic [AB-1:0]    sector_wide;
   logic [FB-1:0]    pos;
   logic [FB:0]      addr_t2;
   logic [FB:0]      addr_t1;
   logic [MB-1:0]    mag_in;

   always_comb begin
      angle_ext   = EXT_W'(req_angle);
      sector_wide = AB'(angle_ext >> FB);
      pos         = angle_ext[FB-1:0];
      sector_ok   = sector_wide < AB'(svpwm_pkg::NUM_SECTORS);
      addr_t2     = (FB+1)'(pos);
      addr_t1     = ((FB+1)'(1) << FB) - (FB+1)'(pos);
      mag_in      = (req_magnitude > svpwm_pkg::MAG_ONE) ? svpwm_pkg::MAG_ONE
                                                          : req_magnitude;
   end

   logic [SINE_BITS-1:0] sin_t1;
   logic [SINE_BITS-1:0] sin_t2;
   logic [MB-1:0]        mag1_ff;
   logic [SB-1:0]        sector1_ff;

   svpwm_sine_rom #(
      .FRAC_BITS (FB),
      .DATA_BITS (SINE_BITS)
   ) u_sine_rom (
      .clock     (clock),
      .rd_en     (load[1]),
      .rd_addr_a (addr_t1),
      .rd_addr_b (addr_t2),
      .rd_data_a (sin_t1),
      .rd_data_b (sin_t2)
   );

   always_ff @(posedge clock) begin
      if (load[1]) begin
         mag1_ff    <= mag_in;
         sector1_ff <= sector_wide[SB-1:0];
      end
   end

   // --------------------------------------------- stage 2: vector times
   logic [MPROD_W-1:0]   t1_prod;
   logic [MPROD_W-1:0]   t2_prod;
   logic [SINE_BITS-1:0] t1_ff;
   logic [SINE_BITS-1:0] t2_ff;
   logic [SB-1:0]        sector2_ff;

   assign t1_prod = MPROD_W'(mag1_ff) * MPROD_W'(sin_t1);
   assign t2_prod = MPROD_W'(mag1_ff) * MPROD_W'(sin_t2);

   always_ff @(posedge clock) begin
      if (load[2]) begin
         t1_ff      <= SINE_BITS'(t1_prod >> svpwm_pkg::MAG_FRAC);
         t2_ff      <= SINE_BITS'(t2_prod >> svpwm_pkg::MAG_FRAC);
         sector2_ff <= sector1_ff;
      end
   end

   // ----------------------------- stage 3: null time and phase fractions
   logic [SINE_BITS:0]     t_sum;
   logic [SINE_BITS:0]     t0;
   logic [SINE_BITS:0]     half;
   logic [SINE_BITS:0]     f_half;
   logic [SINE_BITS:0]     f_t1;
   logic [SINE_BITS:0]     f_t2;
   logic [SINE_BITS:0]     f_all;
   svpwm_pkg::sel_row_type row;
   logic [SINE_BITS:0]     frac_u_ff;
   logic [SINE_BITS:0]     frac_v_ff;
   logic [SINE_BITS:0]     frac_w_ff;
   logic [SB-1:0]          sector3_ff;

   function automatic logic [SINE_BITS:0] pick_frac(input svpwm_pkg::sel_type sel,
                                                    input logic [SINE_BITS:0] fh,
                                                    input logic [SINE_BITS:0] f1,
                                                    input logic [SINE_BITS:0] f2,
                                                    input logic [SINE_BITS:0] fa);
      logic [SINE_BITS:0] r;
      unique case (sel)
         svpwm_pkg::SEL_HALF: r = fh;
         svpwm_pkg::SEL_T1:   r = f1;
         svpwm_pkg::SEL_T2:   r = f2;
         svpwm_pkg::SEL_ALL:  r = fa;
         default:             r = fh;
      endcase
      return r;
   endfunction

   // Clamp the null time at zero when rounding pushes t1 + t2 past one
   always_comb begin
      t_sum  = (SINE_BITS+1)'(t1_ff) + (SINE_BITS+1)'(t2_ff);
      t0     = (t_sum < ((SINE_BITS+1)'(1) << SINE_BITS))
               ? ((SINE_BITS+1)'(1) << SINE_BITS) - t_sum : '0;
      half   = t0 >> 1;
      f_half = half;
      f_t1   = half + (SINE_BITS+1)'(t1_ff);
      f_t2   = half + (SINE_BITS+1)'(t2_ff);
      f_all  = half + t_sum;
      row    = svpwm_pkg::phase_row(sector2_ff);
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         frac_u_ff  <= pick_frac(row.u, f_half, f_t1, f_t2, f_all);
         frac_v_ff  <= pick_frac(row.v, f_half, f_t1, f_t2, f_all);
         frac_w_ff  <= pick_frac(row.w, f_half, f_t1, f_t2, f_all);
         sector3_ff <= sector2_ff;
      end
   end

   // --------------------------------- stages 4 and 5: phase compares
   svpwm_pkg::stage_ctl_type cmp_ctl;
   logic [SB-1:0]            sector4_ff;
   logic [SB-1:0]            sector5_ff;

   assign cmp_ctl.load_mul = load[4];
   assign cmp_ctl.load_out = load[5];

   svpwm_phase_cmp #(.SINE_BITS(SINE_BITS)) u_cmp_u (
      .clock   (clock),
      .ctl     (cmp_ctl),
      .frac    (frac_u_ff),
      .period  (period_ff),
      .compare (rsp_compare_u)
   );

   svpwm_phase_cmp #(.SINE_BITS(SINE_BITS)) u_cmp_v (
      .clock   (clock),
      .ctl     (cmp_ctl),
      .frac    (frac_v_ff),
      .period  (period_ff),
      .compare (rsp_compare_v)
   );

   svpwm_phase_cmp #(.SINE_BITS(SINE_BITS)) u_cmp_w (
      .clock   (clock),
      .ctl     (cmp_ctl),
      .frac    (frac_w_ff),
      .period  (period_ff),
      .compare (rsp_compare_w)
   );

   always_ff @(posedge clock) begin
      if (load[4]) begin
         sector4_ff <= sector3_ff;
      end
      if (load[5]) begin
         sector5_ff <= sector4_ff;
      end
   end

   assign rsp_valid      = valid_ff[STAGES];
   assign rsp_sector_out = sector5_ff;

`ifndef SYNTHESIS
   // Only sectors 0 to 5 reach the output
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sector_out < SB'(svpwm_pkg::NUM_SECTORS)))
      else $error("result beat carries an invalid sector");

   // A compare value never exceeds the period
   a_compare_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_compare_u <= period_ff) && (rsp_compare_v <= period_ff)
                    && (rsp_compare_w <= period_ff))
      else $error("compare value above the period");

   // An accepted beat with an invalid sector leaves the first stage empty
   a_drop_invalid: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !sector_ok) |=> !valid_ff[1])
      else $error("invalid-sector beat entered the pipeline");

   // A blocked stage 2 keeps its beat
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !load[3]) |=> valid_ff[2])
      else $error("stalled beat lost in the multiply stage");

   // A result leaves the pipe only through the output handshake
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sector_out)))
      else $error("output beat changed while stalled");
`endif

endmodule

`default_nettype wire
